// ----- hdl/rpy2q_pkg.sv -----
package rpy2q_pkg;

   localparam int TRIG_ITERATIONS = 16;
   localparam int ATAN_ENTRIES    = 24;
   localparam int CORDIC_STEPS    =
      (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;

   localparam int ANGLE_W = 16;
   localparam int QUAT_W  = 16;
   localparam int TRIG_W  = 32;
   localparam int R_W     = 25;
   localparam int SQ_W    = 48;
   localparam int SUM_W   = 50;
   localparam int ROOT_W  = SUM_W / 2;
   localparam int REM_W   = ROOT_W + 2;
   localparam int QUO_W   = 16;
   localparam int NUM_W   = 40;
   localparam int DIV_W   = NUM_W + 1;
   localparam int OUT_FRAC = 14;

   localparam int SC_LAT    = CORDIC_STEPS + 2;
   localparam int TOTAL_LAT = SC_LAT + 5 + ROOT_W + 1 + QUO_W;

   localparam logic signed [TRIG_W-1:0] ONE_Q28     = 32'sd268435456;
   localparam logic signed [TRIG_W-1:0] HALF_PI_Q28 = 32'sd421657428;
   localparam logic signed [TRIG_W-1:0] PI_Q28      = 32'sd843314857;
   localparam logic [QUO_W-1:0]         OUT_ONE     = 16'd16384;

   localparam logic signed [TRIG_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
      32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
      32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
      32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
      32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
      32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
      32'sd256,       32'sd128,       32'sd64,       32'sd32
   };

   typedef struct packed {
      logic signed [ANGLE_W-1:0] roll_angle;
      logic signed [ANGLE_W-1:0] pitch_angle;
      logic signed [ANGLE_W-1:0] yaw_angle;
   } req_type;

   typedef struct packed {
      logic signed [QUAT_W-1:0] quat_x;
      logic signed [QUAT_W-1:0] quat_y;
      logic signed [QUAT_W-1:0] quat_z;
      logic signed [QUAT_W-1:0] quat_w;
   } rsp_type;

endpackage

// ----- hdl/rpy2q_sincos.sv -----
module rpy2q_sincos (
   input  logic                                    clock,
   input  logic                                    enable,
   input  logic signed [rpy2q_pkg::ANGLE_W-1:0]    angle,
   output logic signed [rpy2q_pkg::TRIG_W-1:0]     cos_out,
   output logic signed [rpy2q_pkg::TRIG_W-1:0]     sin_out
);
   import rpy2q_pkg::*;

   logic signed [TRIG_W-1:0] z_wide;
   logic signed [TRIG_W-1:0] z_in;
   logic                     neg_in;

   logic signed [TRIG_W-1:0] x_ff [CORDIC_STEPS+1];
   logic signed [TRIG_W-1:0] y_ff [CORDIC_STEPS+1];
   logic signed [TRIG_W-1:0] z_ff [CORDIC_STEPS+1];
   logic                     neg_ff [CORDIC_STEPS+1];
   logic signed [TRIG_W-1:0] cos_ff;
   logic signed [TRIG_W-1:0] sin_ff;

   // half angle in units of 2^-28 rad
   assign z_wide = {{(TRIG_W-ANGLE_W-OUT_FRAC){angle[ANGLE_W-1]}}, angle, {OUT_FRAC{1'b0}}};

   // fold into +-pi/2, cosine flips sign
   always_comb begin
      z_in   = z_wide;
      neg_in = 1'b0;
      if (z_wide > HALF_PI_Q28) begin
         z_in   = PI_Q28 - z_wide;
         neg_in = 1'b1;
      end else if (z_wide < -HALF_PI_Q28) begin
         z_in   = -PI_Q28 - z_wide;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]   <= ONE_Q28;
         y_ff[0]   <= '0;
         z_ff[0]   <= z_in;
         neg_ff[0] <= neg_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (enable) begin
            neg_ff[i+1] <= neg_ff[i];
            if (!z_ff[i][TRIG_W-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN_TAB[i];
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN_TAB[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cos_ff <= neg_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
         sin_ff <= y_ff[CORDIC_STEPS];
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

// ----- hdl/rpy2q_isqrt.sv -----
module rpy2q_isqrt (
   input  logic                               clock,
   input  logic                               enable,
   input  logic [rpy2q_pkg::SUM_W-1:0]        radicand,
   output logic [rpy2q_pkg::ROOT_W-1:0]       root
);
   import rpy2q_pkg::*;

   logic [SUM_W-1:0]  rad_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   // one result bit per stage, two radicand bits consumed per stage
   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      localparam int P = ROOT_W - 1 - s;
      logic [SUM_W-1:0]  rad_cur;
      logic [REM_W-1:0]  rem_cur;
      logic [ROOT_W-1:0] root_cur;
      logic [REM_W-1:0]  rem_cat;
      logic [REM_W-1:0]  trial;

      if (s == 0) begin : g_first
         assign rad_cur  = radicand;
         assign rem_cur  = '0;
         assign root_cur = '0;
      end else begin : g_next
         assign rad_cur  = rad_ff[s-1];
         assign rem_cur  = rem_ff[s-1];
         assign root_cur = root_ff[s-1];
      end

      assign rem_cat = {rem_cur[REM_W-3:0], rad_cur[2*P+1 -: 2]};
      assign trial   = {root_cur, 2'b01};

      always_ff @(posedge clock) begin
         if (enable) begin
            rad_ff[s] <= rad_cur;
            if (rem_cat >= trial) begin
               rem_ff[s]  <= rem_cat - trial;
               root_ff[s] <= {root_cur[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[s]  <= rem_cat;
               root_ff[s] <= {root_cur[ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

// ----- hdl/rpy2q_div.sv -----
module rpy2q_div (
   input  logic                              clock,
   input  logic                              enable,
   input  logic [rpy2q_pkg::NUM_W-1:0]       numer,
   input  logic [rpy2q_pkg::ROOT_W-1:0]      denom,
   output logic [rpy2q_pkg::QUO_W-1:0]       quo
);
   import rpy2q_pkg::*;

   logic [DIV_W-1:0]  rem_ff [QUO_W];
   logic [ROOT_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0]  quo_ff [QUO_W];

   // restoring division, quotient known to fit in QUO_W bits
   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      localparam int K = QUO_W - 1 - s;
      logic [DIV_W-1:0]  rem_cur;
      logic [ROOT_W-1:0] den_cur;
      logic [QUO_W-1:0]  quo_cur;
      logic [DIV_W-1:0]  dsh;

      if (s == 0) begin : g_first
         assign rem_cur = {1'b0, numer};
         assign den_cur = denom;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[s-1];
         assign den_cur = den_ff[s-1];
         assign quo_cur = quo_ff[s-1];
      end

      assign dsh = DIV_W'(den_cur) << K;

      always_ff @(posedge clock) begin
         if (enable) begin
            den_ff[s] <= den_cur;
            if (rem_cur >= dsh) begin
               rem_ff[s] <= rem_cur - dsh;
               quo_ff[s] <= quo_cur | (QUO_W'(1) << K);
            end else begin
               rem_ff[s] <= rem_cur;
               quo_ff[s] <= quo_cur;
            end
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

// ----- hdl/euler_rpy_to_quaternion.sv -----
// Roll/pitch/yaw (signed Q2.13 rad) to unit quaternion (signed Q1.14, saturated).
// Fully pipelined: a new request can enter every cycle while req_stall is low, and
// the pipeline depth TOTAL_LAT is set by the CORDIC stages, the 25-stage square
// root and the 16-stage divider. A two-entry output buffer lets requests keep
// flowing while one result waits; req_stall rises only once that buffer is full.
module euler_rpy_to_quaternion (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rpy2q_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rpy2q_pkg::rsp_type  rsp_data
);
   import rpy2q_pkg::*;

   localparam int R_DLY = 2 + ROOT_W;

   logic enable;
   logic valid_ff [TOTAL_LAT];

   logic signed [TRIG_W-1:0] c1, s1, c2, s2, c3, s3;

   // stage p1
   logic signed [TRIG_W-1:0] cc_ff, cs_ff, sc_ff, ss_ff, c3_ff, s3_ff;
   // stage p2
   logic signed [TRIG_W-1:0] t_ff [8];
   // stage p3
   logic signed [R_W-1:0]    r_ff [4];
   logic signed [TRIG_W:0]   q_in [4];
   // stage p4 / p5
   logic [SQ_W-1:0]          sq_ff [4];
   logic [SUM_W-1:0]         sum_ff;
   logic signed [R_W-1:0]    r_dly_ff [R_DLY][4];

   logic [ROOT_W-1:0]        root;
   logic [NUM_W-1:0]         num_ff [4];
   logic [ROOT_W-1:0]        den_ff;
   logic                     sign_ff [QUO_W+1][4];
   logic                     zero_ff [QUO_W+1];
   logic [QUO_W-1:0]         quo [4];

   rsp_type                  res_in;
   rsp_type                  main_ff, skid_ff;
   logic                     main_valid_ff, skid_valid_ff;

   assign enable    = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL_LAT; i++) valid_ff[i] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < TOTAL_LAT; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   rpy2q_sincos u_roll (.clock, .enable, .angle(req_data.roll_angle),
      .cos_out(c1), .sin_out(s1));
   rpy2q_sincos u_pitch (.clock, .enable, .angle(req_data.pitch_angle),
      .cos_out(c2), .sin_out(s2));
   rpy2q_sincos u_yaw (.clock, .enable, .angle(req_data.yaw_angle),
      .cos_out(c3), .sin_out(s3));

   function automatic logic signed [TRIG_W-1:0] mul_q28(logic signed [TRIG_W-1:0] a,
                                                        logic signed [TRIG_W-1:0] b);
      logic signed [2*TRIG_W-1:0] p;
      p = a * b;
      return p[TRIG_W+27:28];
   endfunction

   always_ff @(posedge clock) begin
      if (enable) begin
         cc_ff <= mul_q28(c1, c2);
         cs_ff <= mul_q28(c1, s2);
         sc_ff <= mul_q28(s1, c2);
         ss_ff <= mul_q28(s1, s2);
         c3_ff <= c3;
         s3_ff <= s3;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         t_ff[0] <= mul_q28(sc_ff, c3_ff);
         t_ff[1] <= mul_q28(cs_ff, s3_ff);
         t_ff[2] <= mul_q28(cs_ff, c3_ff);
         t_ff[3] <= mul_q28(sc_ff, s3_ff);
         t_ff[4] <= mul_q28(cc_ff, s3_ff);
         t_ff[5] <= mul_q28(ss_ff, c3_ff);
         t_ff[6] <= mul_q28(cc_ff, c3_ff);
         t_ff[7] <= mul_q28(ss_ff, s3_ff);
      end
   end

   always_comb begin
      q_in[0] = (TRIG_W+1)'(t_ff[0]) - (TRIG_W+1)'(t_ff[1]);
      q_in[1] = (TRIG_W+1)'(t_ff[2]) + (TRIG_W+1)'(t_ff[3]);
      q_in[2] = (TRIG_W+1)'(t_ff[4]) - (TRIG_W+1)'(t_ff[5]);
      q_in[3] = (TRIG_W+1)'(t_ff[6]) + (TRIG_W+1)'(t_ff[7]);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 4; k++) r_ff[k] <= q_in[k][R_W+7:8];
      end
   end

   always_ff @(posedge clock) begin
      logic signed [2*R_W-1:0] sq;
      if (enable) begin
         for (int k = 0; k < 4; k++) begin
            sq = r_ff[k] * r_ff[k];
            sq_ff[k] <= sq[SQ_W-1:0];
         end
         sum_ff <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2])
                 + SUM_W'(sq_ff[3]);
      end
   end

   // components ride alongside the square and root stages
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 4; k++) r_dly_ff[0][k] <= r_ff[k];
         for (int d = 1; d < R_DLY; d++) begin
            for (int k = 0; k < 4; k++) r_dly_ff[d][k] <= r_dly_ff[d-1][k];
         end
      end
   end

   rpy2q_isqrt u_isqrt (.clock, .enable, .radicand(sum_ff), .root);

   always_ff @(posedge clock) begin
      logic signed [R_W-1:0] rv;
      logic [R_W-1:0]        mag;
      if (enable) begin
         for (int k = 0; k < 4; k++) begin
            rv  = r_dly_ff[R_DLY-1][k];
            mag = rv[R_W-1] ? R_W'(-rv) : R_W'(rv);
            num_ff[k]     <= {1'b0, mag, {OUT_FRAC{1'b0}}} + NUM_W'(root >> 1);
            sign_ff[0][k] <= rv[R_W-1];
         end
         den_ff     <= root;
         zero_ff[0] <= (root == '0);
         for (int d = 1; d <= QUO_W; d++) begin
            sign_ff[d] <= sign_ff[d-1];
            zero_ff[d] <= zero_ff[d-1];
         end
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_div
      rpy2q_div u_div (.clock, .enable, .numer(num_ff[k]), .denom(den_ff), .quo(quo[k]));
   end

   always_comb begin
      logic [QUO_W-1:0]        sat [4];
      logic signed [QUAT_W-1:0] v [4];
      for (int k = 0; k < 4; k++) begin
         sat[k] = (quo[k] > OUT_ONE) ? OUT_ONE : quo[k];
         v[k]   = sign_ff[QUO_W][k] ? -$signed(sat[k]) : $signed(sat[k]);
      end
      if (zero_ff[QUO_W]) begin
         res_in.quat_x = '0;
         res_in.quat_y = '0;
         res_in.quat_z = '0;
         res_in.quat_w = $signed(OUT_ONE);
      end else begin
         res_in.quat_x = v[0];
         res_in.quat_y = v[1];
         res_in.quat_z = v[2];
         res_in.quat_w = v[3];
      end
   end

   // output register plus skid entry
   always_ff @(posedge clock) begin
      logic pop;
      logic push;
      pop  = main_valid_ff && !rsp_stall;
      push = enable && valid_ff[TOTAL_LAT-1];
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            main_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_ff       <= res_in;
            main_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= res_in;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

endmodule

// ----- hdl/rpy2q_checker.sv -----
module rpy2q_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input rpy2q_pkg::rsp_type rsp_data
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result changed while stalled");

   // buffer only fills behind a waiting result
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty output");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.quat_x <= 16'sd16384 && rsp_data.quat_x >= -16'sd16384
                 && rsp_data.quat_y <= 16'sd16384 && rsp_data.quat_y >= -16'sd16384
                 && rsp_data.quat_z <= 16'sd16384 && rsp_data.quat_z >= -16'sd16384
                 && rsp_data.quat_w <= 16'sd16384 && rsp_data.quat_w >= -16'sd16384)
      else $error("component out of range");

endmodule

bind euler_rpy_to_quaternion rpy2q_checker u_checker (.*);
